@@ design/hhf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhf_pkg: shared types and constants of the heater controller
// Mode codes, register indexes, field widths and the config bundle.
// ----------------------------------------------------------------------------
package hhf_pkg;

    localparam int TEMP_W   = 9;
    localparam int HYST_W   = 8;
    localparam int SETTLE_W = 32;
    localparam int STAMP_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // temperature reported for a failed sensor read
    localparam logic signed [TEMP_W-1:0] FAIL_TEMP = -9'sd200;

    localparam logic signed [TEMP_W-1:0] TARGET_RST   = 9'sd80;
    localparam logic [HYST_W-1:0]        HYST_RST     = 8'd4;
    localparam logic signed [TEMP_W-1:0] OVERHEAT_RST = 9'sd100;
    localparam logic [SETTLE_W-1:0]      SETTLE_RST   = 32'd5000;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_HEAT = 3'd1,
        MODE_STAB = 3'd2,
        MODE_DONE = 3'd3,
        MODE_OVER = 3'd4
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET   = 2'd0,
        CFG_HYST     = 2'd1,
        CFG_OVERHEAT = 2'd2,
        CFG_SETTLE   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [TEMP_W-1:0] target;
        logic [HYST_W-1:0]        hyst;
        logic signed [TEMP_W-1:0] overheat;
        logic [SETTLE_W-1:0]      settle;
    } t_cfg;

endpackage

@@ design/hhf_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhf_decode: sensor byte decoder
// Builds the signed half-degree temperature from the two sensor bytes.
// ----------------------------------------------------------------------------
module hhf_decode (
    input  logic [hhf_pkg::BYTE_W-1:0]        i_msb,
    input  logic [hhf_pkg::BYTE_W-1:0]        i_lsb,
    input  logic                              i_read_ok,
    output logic signed [hhf_pkg::TEMP_W-1:0] o_temp
);
    import hhf_pkg::*;

    // integer degrees plus the half-degree bit, read as two's complement
    always_comb begin
        if (i_read_ok) begin
            o_temp = signed'({i_msb, i_lsb[BYTE_W-1]});
        end else begin
            o_temp = FAIL_TEMP;
        end
    end

endmodule

@@ design/hhf_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhf_cfg: configuration registers
// Target, hysteresis band, overheat limit and settle time.
// ----------------------------------------------------------------------------
module hhf_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [hhf_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [hhf_pkg::CFG_W-1:0]       i_data,
    output hhf_pkg::t_cfg                   o_cfg
);
    import hhf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target   <= TARGET_RST;
            r_cfg.hyst     <= HYST_RST;
            r_cfg.overheat <= OVERHEAT_RST;
            r_cfg.settle   <= SETTLE_RST;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_TARGET:   r_cfg.target   <= signed'(i_data[TEMP_W-1:0]);
                CFG_HYST:     r_cfg.hyst     <= i_data[HYST_W-1:0];
                CFG_OVERHEAT: r_cfg.overheat <= signed'(i_data[TEMP_W-1:0]);
                CFG_SETTLE:   r_cfg.settle   <= i_data[SETTLE_W-1:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/hhf_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhf_ctrl: thermostat mode machine
// Hysteresis heating, timed stabilizing and the overheat override.
// ----------------------------------------------------------------------------
module hhf_ctrl #(
    parameter int TIME_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic signed [hhf_pkg::TEMP_W-1:0] i_temp,
    input  logic [hhf_pkg::STAMP_W-1:0]       i_now,
    input  hhf_pkg::t_cfg                     i_cfg,
    output hhf_pkg::t_mode                    o_mode,
    output logic                              o_heater,
    output logic                              o_led
);
    import hhf_pkg::*;

    localparam int CMP_W = (TIME_BITS > SETTLE_W) ? TIME_BITS : SETTLE_W;

    t_mode                r_mode, n_mode;
    logic                 r_heater, n_heater;
    logic                 r_led, n_led;
    logic [TIME_BITS-1:0] r_entry, n_entry;

    logic [TIME_BITS-1:0]      now_t;
    logic [TIME_BITS-1:0]      elapsed;
    logic                      settled;
    logic signed [TEMP_W:0]    low_band;
    logic                      below_low;
    logic                      below_target;
    logic                      hot;
    logic                      moved;

    assign now_t        = TIME_BITS'(i_now);
    assign elapsed      = now_t - r_entry;
    assign settled      = CMP_W'(elapsed) >= CMP_W'(i_cfg.settle);
    assign low_band     = (TEMP_W+1)'(i_cfg.target) - signed'({2'b00, i_cfg.hyst});
    assign below_low    = (TEMP_W+1)'(i_temp) < low_band;
    assign below_target = i_temp < i_cfg.target;
    assign hot          = i_temp >= i_cfg.overheat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_heater <= 1'b0;
            r_led    <= 1'b0;
            r_entry  <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_heater <= n_heater;
            r_led    <= n_led;
            r_entry  <= n_entry;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_heater = r_heater;
        n_led    = r_led;
        moved    = 1'b0;
        case (r_mode)
            MODE_IDLE: begin
                if (below_low) begin
                    n_mode = MODE_HEAT;
                    moved  = 1'b1;
                end
            end
            MODE_HEAT: begin
                n_heater = 1'b1;
                if (!below_target) begin
                    n_mode = MODE_STAB;
                    moved  = 1'b1;
                end
            end
            MODE_STAB: begin
                n_heater = 1'b0;
                if (settled) begin
                    n_mode = MODE_DONE;
                    moved  = 1'b1;
                end
            end
            MODE_DONE: begin
                n_heater = 1'b0;
                if (below_low) begin
                    n_mode = MODE_HEAT;
                    moved  = 1'b1;
                end
            end
            MODE_OVER: begin
                n_heater = 1'b0;
                n_led    = 1'b1;
                if (below_target) begin
                    n_led  = 1'b0;
                    n_mode = MODE_IDLE;
                    moved  = 1'b1;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        // overheat override, heater and led follow on the next reading
        if (hot && n_mode != MODE_OVER) begin
            n_mode = MODE_OVER;
            moved  = 1'b1;
        end
        n_entry = moved ? now_t : r_entry;
    end

    assign o_mode   = n_mode;
    assign o_heater = n_heater;
    assign o_led    = n_led;

    // led is only lit while overheated
    a_led_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_led |-> r_mode == MODE_OVER)
        else $error("warning led lit outside overheat");

    // target reached never drives the heater
    a_done_cold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_DONE |-> !r_heater)
        else $error("heater on in target reached");

    // state moves only on a reading
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_mode) && $stable(r_entry))
        else $error("state changed without a reading");

endmodule

@@ design/heater_hysteresis_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_hysteresis_fsm: thermostat controller with hysteresis and overheat
// One temperature reading in, one mode/heater/led/temperature word out.
// ----------------------------------------------------------------------------
// Each input word is one sensor reading; each produces exactly one result
// word, in order. A word passes an input register, then the decode and mode
// logic, then the result register. A new reading is taken every cycle,
// throughput set only by the output handshake (the input register takes
// one more word while a result waits, then stalls). Temperatures are signed
// half-degree values; a failed read counts as -200 half-degrees.
// Modes: 0 idle, 1 heating, 2 stabilizing, 3 target reached, 4 overheat.
// The settle timer compares now_ms against the timestamp of the last mode
// change modulo 2^TIME_BITS. Configuration writes are taken at any edge
// with i_cfg_we high; write them only while no reading is in flight.
// ----------------------------------------------------------------------------
module heater_hysteresis_fsm #(
    parameter int TIME_BITS = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // reading stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [7:0] sensor_msb, [15:8] sensor_lsb, [47:16] now_ms
    input  logic [47:0]                      i_s_axis_tdata,
    // [0] read_ok
    input  logic                             i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [2:0] mode, [3] heater_on, [4] warning_led, [13:5] temp_half_c, [15:14] zero
    output logic [15:0]                      o_m_axis_tdata,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [hhf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hhf_pkg::CFG_W-1:0]        i_cfg_data
);
    import hhf_pkg::*;

    // input register
    logic                     r_in_valid;
    logic [BYTE_W-1:0]        r_msb;
    logic [BYTE_W-1:0]        r_lsb;
    logic                     r_ok;
    logic [STAMP_W-1:0]       r_now;

    // result register
    logic                     r_out_valid;
    t_mode                    r_mode;
    logic                     r_heater;
    logic                     r_led;
    logic signed [TEMP_W-1:0] r_temp;

    logic                     advance;   // result register free this cycle
    logic                     s_accept;
    logic                     step;      // reading moves into the result register
    logic signed [TEMP_W-1:0] temp;
    t_cfg                     cfg;
    t_mode                    step_mode;
    logic                     step_heater;
    logic                     step_led;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign step            = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_msb <= i_s_axis_tdata[7:0];
            r_lsb <= i_s_axis_tdata[15:8];
            r_now <= i_s_axis_tdata[47:16];
            r_ok  <= i_s_axis_tuser;
        end
    end

    hhf_decode u_decode (
        .i_msb     (r_msb),
        .i_lsb     (r_lsb),
        .i_read_ok (r_ok),
        .o_temp    (temp)
    );

    hhf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hhf_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_temp   (temp),
        .i_now    (r_now),
        .i_cfg    (cfg),
        .o_mode   (step_mode),
        .o_heater (step_heater),
        .o_led    (step_led)
    );

    // result valid follows the input register whenever the output is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_mode   <= step_mode;
            r_heater <= step_heater;
            r_led    <= step_led;
            r_temp   <= temp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_temp, r_led, r_heater, r_mode};

    // both registers full and output stalled: no room for another word
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("reading taken with no room");

    // a pending reading is always followed by a valid result
    a_step_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("reading stepped but result not valid");

endmodule

@@ verif/heater_hysteresis_fsm_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_hysteresis_fsm_tb: self-checking bench for the heater controller
// Drives sensor readings and register writes, tracks the thermostat state
// in a scoreboard and checks every result word field by field.
// ----------------------------------------------------------------------------
// A directed run walks the mode machine through each transition: overheat
// from every mode, failed reads, decode extremes and a settle timer that
// wraps the timestamp. Several configuration phases follow, register
// extremes among them. Each phase sends random readings clustered around
// the target, the hysteresis edge and the overheat limit, with exact settle
// boundaries and random timestamp jumps. Idling on both streams changes
// per phase.
// ----------------------------------------------------------------------------
module heater_hysteresis_fsm_tb;
    import hhf_pkg::*;

    localparam int          CLK_HALF     = 4;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int          PHASES       = 8;
    localparam int          PHASE_WORDS  = 100;
    // two register stages between input and result
    localparam int          DRAIN_CYCLES = 4;

    // one expected result word
    typedef struct packed {
        logic [2:0]        mode;
        logic              heater;
        logic              led;
        logic [TEMP_W-1:0] temp;
    } t_status_word;

    // ------------------------------------------------------------------------
    // scoreboard: thermostat state, register copy and pending results
    // ------------------------------------------------------------------------
    class t_thermostat_scoreboard;
        int                target_hc;
        int                hyst_hc;
        int                overheat_hc;
        logic [31:0]       settle_ms;
        t_mode             mode;
        logic [31:0]       entry_ms;
        logic              heater;
        logic              led;
        t_status_word      pending_results[$];
        int unsigned       failures;

        function new();
            target_hc   = int'(TARGET_RST);
            hyst_hc     = int'(HYST_RST);
            overheat_hc = int'(OVERHEAT_RST);
            settle_ms   = SETTLE_RST;
            mode        = MODE_IDLE;
            entry_ms    = '0;
            heater      = 1'b0;
            led         = 1'b0;
            failures    = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_TARGET:   target_hc   = int'($signed(data[TEMP_W-1:0]));
                CFG_HYST:     hyst_hc     = int'(data[HYST_W-1:0]);
                CFG_OVERHEAT: overheat_hc = int'($signed(data[TEMP_W-1:0]));
                CFG_SETTLE:   settle_ms   = data[SETTLE_W-1:0];
                default: ;
            endcase
        endfunction

        // every mode change restarts the settle timer
        function void enter_mode(t_mode m, logic [31:0] now_ms);
            mode     = m;
            entry_ms = now_ms;
        endfunction

        function void note_reading(logic [7:0] msb, logic [7:0] lsb, logic ok,
                                   logic [31:0] now_ms);
            int           temp;
            int           low_band;
            t_status_word exp_word;
            temp     = ok ? int'($signed({msb, lsb[7]})) : int'(FAIL_TEMP);
            low_band = target_hc - hyst_hc;
            case (mode)
                MODE_IDLE: begin
                    if (temp < low_band) enter_mode(MODE_HEAT, now_ms);
                end
                MODE_HEAT: begin
                    heater = 1'b1;
                    if (temp >= target_hc) enter_mode(MODE_STAB, now_ms);
                end
                MODE_STAB: begin
                    heater = 1'b0;
                    if ((now_ms - entry_ms) >= settle_ms) enter_mode(MODE_DONE, now_ms);
                end
                MODE_DONE: begin
                    heater = 1'b0;
                    if (temp < low_band) enter_mode(MODE_HEAT, now_ms);
                end
                MODE_OVER: begin
                    heater = 1'b0;
                    led    = 1'b1;
                    if (temp < target_hc) begin
                        led = 1'b0;
                        enter_mode(MODE_IDLE, now_ms);
                    end
                end
                default: ;
            endcase
            // overheat wins from any mode, outputs follow on the next reading
            if (temp >= overheat_hc && mode != MODE_OVER) enter_mode(MODE_OVER, now_ms);
            exp_word.mode   = mode;
            exp_word.heater = heater;
            exp_word.led    = led;
            exp_word.temp   = temp[TEMP_W-1:0];
            pending_results.push_back(exp_word);
        endfunction

        function void check_result(logic [15:0] word);
            t_status_word exp_word;
            if (pending_results.size() == 0) begin
                $error("result word %h with no reading pending", word);
                failures++;
                return;
            end
            exp_word = pending_results.pop_front();
            if (word[2:0] !== exp_word.mode) begin
                $error("mode: expected %0d, got %0d", exp_word.mode, word[2:0]);
                failures++;
            end
            if (word[3] !== exp_word.heater) begin
                $error("heater_on: expected %0d, got %0d", exp_word.heater, word[3]);
                failures++;
            end
            if (word[4] !== exp_word.led) begin
                $error("warning_led: expected %0d, got %0d", exp_word.led, word[4]);
                failures++;
            end
            if (word[13:5] !== exp_word.temp) begin
                $error("temp_half_c: expected %0d, got %0d",
                       $signed(exp_word.temp), $signed(word[13:5]));
                failures++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // [7:0] sensor_msb, [15:8] sensor_lsb, [47:16] now_ms
    logic [47:0]          i_s_axis_tdata  = '0;
    // [0] read_ok
    logic                 i_s_axis_tuser  = 1'b0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // [2:0] mode, [3] heater_on, [4] warning_led, [13:5] temp_half_c
    logic [15:0]          o_m_axis_tdata;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = '0;
    logic [CFG_W-1:0]     i_cfg_data      = '0;

    // idling odds in percent, changed between phases
    int                   sender_idle_pct   = 0;
    int                   receiver_stall_pct = 0;
    int unsigned          cycle_count       = 0;

    t_thermostat_scoreboard sb;

    always #CLK_HALF i_clk = ~i_clk;

    heater_hysteresis_fsm #(
        .TIME_BITS(32)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // result side: check the accepted word, then pick next cycle's ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
        i_m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // hang guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("heater_hysteresis_fsm_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    // one reading word, with random idle cycles ahead of it
    task automatic send_reading(input logic [7:0] msb, input logic [7:0] lsb,
                                input logic ok, input logic [31:0] now_ms);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {now_ms, lsb, msb};
        i_s_axis_tuser  <= ok;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_reading(msb, lsb, ok, now_ms);
    endtask

    // drop valid and wait for every pending result plus the pipeline depth
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // unused upper data bits carry random junk, the block must ignore them
    task automatic write_config(input int tgt, input int hys, input int ovh,
                                input logic [31:0] stl);
        logic [CFG_W-1:0] data;
        data = $urandom();
        data[TEMP_W-1:0] = tgt[TEMP_W-1:0];
        write_reg(CFG_TARGET, data);
        data = $urandom();
        data[HYST_W-1:0] = hys[HYST_W-1:0];
        write_reg(CFG_HYST, data);
        data = $urandom();
        data[TEMP_W-1:0] = ovh[TEMP_W-1:0];
        write_reg(CFG_OVERHEAT, data);
        write_reg(CFG_SETTLE, stl);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int          pick;
        int          base;
        int          t;
        int          tgt;
        int          hys;
        int          ovh;
        logic [31:0] stl;
        logic [8:0]  tv;
        logic [7:0]  msb;
        logic [7:0]  lsb;
        logic        ok;
        logic [31:0] stamp;

        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk, reset register values: target 80, band 4, limit 100
        send_reading(8'h00, 8'h00, 1'b1, 32'd0);        // cold, idle to heating
        send_reading(8'h14, 8'h80, 1'b1, 32'd10);       // heater comes on
        send_reading(8'h28, 8'h00, 1'b1, 32'd100);      // at target, stabilizing
        send_reading(8'h28, 8'h00, 1'b1, 32'd5099);     // one ms short of settle
        send_reading(8'h28, 8'h00, 1'b1, 32'd5100);     // settle reached exactly
        send_reading(8'h26, 8'h80, 1'b1, 32'd5200);     // inside the band, hold
        send_reading(8'h25, 8'h80, 1'b1, 32'd5300);     // below band, reheat
        send_reading(8'h32, 8'h00, 1'b1, 32'd5400);     // overheat from heating
        send_reading(8'h2D, 8'h00, 1'b1, 32'd5500);     // still hot, led on
        send_reading(8'h27, 8'h80, 1'b1, 32'd5600);     // cooled, back to idle
        send_reading(8'hFF, 8'hFF, 1'b0, 32'd5700);     // failed read
        send_reading(8'h7F, 8'h80, 1'b1, 32'd5800);     // hottest code
        send_reading(8'h80, 8'h00, 1'b1, 32'd5900);     // coldest code
        send_reading(8'hFF, 8'h80, 1'b1, 32'hFFFF_FFF0);
        send_reading(8'h29, 8'h00, 1'b1, 32'hFFFF_FFF8);
        send_reading(8'hFF, 8'h7F, 1'b1, 32'h0000_1380); // settle across wrap
        send_reading(8'h32, 8'h00, 1'b0, 32'h0000_1400); // failed read, hot bytes
        send_reading(8'h29, 8'h00, 1'b1, 32'd1500);
        send_reading(8'h32, 8'h00, 1'b1, 32'd1600);     // overheat from stabilizing
        send_reading(8'h00, 8'h00, 1'b1, 32'd1700);
        send_reading(8'h32, 8'h00, 1'b1, 32'd1800);     // overheat from idle
        send_reading(8'h00, 8'h00, 1'b1, 32'd1900);
        send_reading(8'h00, 8'h00, 1'b1, 32'd2000);
        send_reading(8'h28, 8'h00, 1'b1, 32'd2100);
        send_reading(8'h28, 8'h00, 1'b1, 32'd9000);
        send_reading(8'h32, 8'h00, 1'b1, 32'd9100);     // overheat from reached
        drain_results();

        stamp = 32'd10000;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    tgt = 80; hys = 4; ovh = 100; stl = 32'd5000;
                end
                1: begin
                    tgt = 60; hys = 6; ovh = 120; stl = 32'd30;
                end
                2: begin
                    tgt = -256; hys = 0; ovh = 255; stl = 32'd0;
                end
                3: begin
                    tgt = 255; hys = 255; ovh = -256; stl = 32'hFFFF_FFFF;
                end
                default: begin
                    tgt = int'($urandom_range(0, 200)) - 60;
                    hys = int'($urandom_range(0, 12));
                    ovh = tgt + int'($urandom_range(1, 60));
                    if (ovh > 255) ovh = 255;
                    stl = $urandom_range(0, 40);
                end
            endcase
            write_config(tgt, hys, ovh, stl);

            // none, sender idle, receiver stall, both
            case (phase % 4)
                0: begin
                    sender_idle_pct = 0; receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct = 87; receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct = 0; receiver_stall_pct = 87;
                end
                default: begin
                    sender_idle_pct = 30; receiver_stall_pct = 30;
                end
            endcase

            for (int n = 0; n < PHASE_WORDS; n++) begin
                // temperature near the decision points, sometimes anywhere
                pick = $urandom_range(0, 99);
                if (pick < 30) base = sb.target_hc;
                else if (pick < 55) base = sb.target_hc - sb.hyst_hc;
                else if (pick < 75) base = sb.overheat_hc;
                else base = int'($urandom_range(0, 511)) - 256;
                t = base;
                if (pick < 75) t = base + int'($urandom_range(0, 6)) - 3;
                if (t < -256) t = -256;
                if (t > 255) t = 255;
                tv  = t[8:0];
                msb = tv[8:1];
                lsb = {tv[0], 7'($urandom())};
                ok  = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    ok  = 1'b0;
                    msb = 8'($urandom());
                    lsb = 8'($urandom());
                end else if (pick < 20) begin
                    msb = 8'($urandom());
                    lsb = 8'($urandom());
                end

                // small steps, exact settle edges and random jumps
                pick = $urandom_range(0, 99);
                if (pick < 80) stamp = stamp + $urandom_range(0, 15);
                else if (pick < 90) stamp = sb.entry_ms + sb.settle_ms - $urandom_range(0, 1);
                else stamp = $urandom();

                send_reading(msb, lsb, ok, stamp);

                // hold off until the block has emptied once
                if (phase == 1 && n == PHASE_WORDS / 2) drain_results();
            end
            drain_results();
        end

        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("heater_hysteresis_fsm_tb OK");
        end else begin
            $display("heater_hysteresis_fsm_tb NOT OK");
        end
        $finish;
    end

endmodule
